>>> rtl/feistel_cipher_16bit_sbox_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for feistel_cipher_16bit_sbox_top
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_CIPHER_16BIT_SBOX_TOP_DEFINES_SVH
`define FEISTEL_CIPHER_16BIT_SBOX_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define FCS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen outside reset.
`define FCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> rtl/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg
// Types, constants and the substitution table of the 16-bit Feistel cipher.
// ----------------------------------------------------------------------------
package fcs_pkg;

	localparam int ROUNDS_DEF      = 64;
	localparam int ROTATE_BITS_DEF = 3;

	// opcodes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// key length modes
	localparam logic KEY_LEN_8  = 1'b0;
	localparam logic KEY_LEN_16 = 1'b1;

	// configuration register indexes
	localparam int          CFG_IDX_W    = 2;
	localparam logic [1:0]  CFG_KEY_LOW  = 2'd0;
	localparam logic [1:0]  CFG_KEY_HIGH = 2'd1;
	localparam logic [1:0]  CFG_KEY_MODE = 2'd2;

	typedef struct packed {
		logic       opcode;
		logic [7:0] left_byte;
		logic [7:0] right_byte;
	} fcs_in_t;

	typedef struct packed {
		logic [7:0] out_left;
		logic [7:0] out_right;
	} fcs_out_t;

	// word moving down the round pipeline
	typedef struct packed {
		logic       opcode;
		logic [7:0] left;
		logic [7:0] right;
	} fcs_word_t;

	typedef struct packed {
		logic [63:0] high;
		logic [63:0] low;
		logic        mode;
	} fcs_key_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hFC, 8'hEE, 8'hDD, 8'h11, 8'hCF, 8'h6E, 8'h31, 8'h16,
		8'hFB, 8'hC4, 8'hFA, 8'hDA, 8'h23, 8'hC5, 8'h04, 8'h4D,
		8'hE9, 8'h77, 8'hF0, 8'hDB, 8'h93, 8'h2E, 8'h99, 8'hBA,
		8'h17, 8'h36, 8'hF1, 8'hBB, 8'h14, 8'hCD, 8'h5F, 8'hC1,
		8'hF9, 8'h18, 8'h65, 8'h5A, 8'hE2, 8'h5C, 8'hEF, 8'h21,
		8'h81, 8'h1C, 8'h3C, 8'h42, 8'h8B, 8'h01, 8'h8E, 8'h4F,
		8'h05, 8'h84, 8'h02, 8'hAE, 8'hE3, 8'h6A, 8'h8F, 8'hA0,
		8'h06, 8'h0B, 8'hED, 8'h98, 8'h7F, 8'hD4, 8'hD3, 8'h1F,
		8'hEB, 8'h34, 8'h2C, 8'h51, 8'hEA, 8'hC8, 8'h48, 8'hAB,
		8'hF2, 8'h2A, 8'h68, 8'hA2, 8'hFD, 8'h3A, 8'hCE, 8'hCC,
		8'hB5, 8'h70, 8'h0E, 8'h56, 8'h08, 8'h0C, 8'h76, 8'h12,
		8'hBF, 8'h72, 8'h13, 8'h47, 8'h9C, 8'hB7, 8'h5D, 8'h87,
		8'h15, 8'hA1, 8'h96, 8'h29, 8'h10, 8'h7B, 8'h9A, 8'hC7,
		8'hF3, 8'h91, 8'h78, 8'h6F, 8'h9D, 8'h9E, 8'hB2, 8'hB1,
		8'h32, 8'h75, 8'h19, 8'h3D, 8'hFF, 8'h35, 8'h8A, 8'h7E,
		8'h6D, 8'h54, 8'hC6, 8'h80, 8'hC3, 8'hBD, 8'h0D, 8'h57,
		8'hDF, 8'hF5, 8'h24, 8'hA9, 8'h3E, 8'hA8, 8'h43, 8'hC9,
		8'hD7, 8'h79, 8'hD6, 8'hF6, 8'h7C, 8'h22, 8'hB9, 8'h03,
		8'hE0, 8'h0F, 8'hEC, 8'hDE, 8'h7A, 8'h94, 8'hB0, 8'hBC,
		8'hDC, 8'hE8, 8'h28, 8'h50, 8'h4E, 8'h33, 8'h0A, 8'h4A,
		8'hA7, 8'h97, 8'h60, 8'h73, 8'h1E, 8'h00, 8'h62, 8'h44,
		8'h1A, 8'hB8, 8'h38, 8'h82, 8'h64, 8'h9F, 8'h26, 8'h41,
		8'hAD, 8'h45, 8'h46, 8'h92, 8'h27, 8'h5E, 8'h55, 8'h2F,
		8'h8C, 8'hA3, 8'hA5, 8'h7D, 8'h69, 8'hD5, 8'h95, 8'h3B,
		8'h07, 8'h58, 8'hB3, 8'h40, 8'h86, 8'hAC, 8'h1D, 8'hF7,
		8'h30, 8'h37, 8'h6B, 8'hE4, 8'h88, 8'hD9, 8'hE7, 8'h89,
		8'hE1, 8'h1B, 8'h83, 8'h49, 8'h4C, 8'h3F, 8'hF8, 8'hFE,
		8'h8D, 8'h53, 8'hAA, 8'h90, 8'hCA, 8'hD8, 8'h85, 8'h61,
		8'h20, 8'h71, 8'h67, 8'hA4, 8'h2D, 8'h2B, 8'h09, 8'h5B,
		8'hCB, 8'h9B, 8'h25, 8'hD0, 8'hBE, 8'hE5, 8'h6C, 8'h52,
		8'h59, 8'hA6, 8'h74, 8'hD2, 8'hE6, 8'hF4, 8'hB4, 8'hC0,
		8'hD1, 8'h66, 8'hAF, 8'hC2, 8'h39, 8'h4B, 8'h63, 8'hB6
	};

	function automatic logic [7:0] fcs_sbox(input logic [7:0] v);
		return SBOX[v];
	endfunction

endpackage

>>> rtl/feistel_cipher_16bit_sbox_top.sv
// ----------------------------------------------------------------------------
// feistel_cipher_16bit_sbox_top
// 16-bit Feistel cipher with an 8-bit S-box round, fully unrolled pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd (opcode, left_byte, right_byte) and pulse start; a word is
//   taken at every edge where start is high and busy is low. busy stays low,
//   so a new word may enter in every cycle.
//   Each accepted word passes through every round register in order: done is
//   high for one cycle with the encrypted or decrypted block on result.
//   Throughput is one word per cycle; each pipeline stage holds one round,
//   made of an S-box lookup, key XOR, rotate and XOR.
//   The receiver cannot stall; results appear in acceptance order.
//   Key registers are written through cfg_we / cfg_index / cfg_data: index 0
//   key bytes 0-7, index 1 key bytes 8-15, index 2 key length (bit 0).
//   Write them only while no word is in flight; other indexes are ignored.
//   Reset clears the keys, the key length and all stage valid bits, so no
//   result appears until a word is started after reset.
// ----------------------------------------------------------------------------
`include "feistel_cipher_16bit_sbox_top_defines.svh"

module feistel_cipher_16bit_sbox_top
	import fcs_pkg::*;
#(
	parameter int ROUNDS      = ROUNDS_DEF,
	parameter int ROTATE_BITS = ROTATE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fcs_in_t              cmd,
	output logic                 done,
	output fcs_out_t             result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic        key_mode_q;
	fcs_key_t    key;

	logic      stage_valid [ROUNDS+1];
	fcs_word_t stage_word  [ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_mode_q <= KEY_LEN_8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_MODE: key_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign key.low  = key_low_q;
	assign key.high = key_high_q;
	assign key.mode = key_mode_q;

	assign busy = 1'b0;

	assign stage_valid[0]       = start && !busy;
	assign stage_word[0].opcode = cmd.opcode;
	assign stage_word[0].left   = cmd.left_byte;
	assign stage_word[0].right  = cmd.right_byte;

	for (genvar i = 0; i < ROUNDS; i++) begin : g_round
		fcs_round #(
			.ROUNDS      (ROUNDS),
			.ROUND_IDX   (i),
			.ROTATE_BITS (ROTATE_BITS)
		) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[i]),
			.in_word   (stage_word[i]),
			.key       (key),
			.out_valid (stage_valid[i+1]),
			.out_word  (stage_word[i+1])
		);
	end

	assign done             = stage_valid[ROUNDS];
	assign result.out_left  = stage_word[ROUNDS].left;
	assign result.out_right = stage_word[ROUNDS].right;

	`FCS_ASSERT(a_start_to_done, clk, arst_n, (start && !busy) |-> ##ROUNDS done, "word lost")
	`FCS_ASSERT(a_done_has_start, clk, arst_n, done |-> $past(start, ROUNDS), "stray done")
	`FCS_ASSERT_NEVER(a_cfg_in_flight, clk, arst_n, cfg_we && done, "key write in flight")

endmodule

>>> rtl/fcs_round.sv
// ----------------------------------------------------------------------------
// fcs_round
// One Feistel round and its pipeline register; the last round skips the swap.
// ----------------------------------------------------------------------------
module fcs_round
	import fcs_pkg::*;
#(
	parameter int ROUNDS      = ROUNDS_DEF,
	parameter int ROUND_IDX   = 0,
	parameter int ROTATE_BITS = ROTATE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  fcs_word_t in_word,
	input  fcs_key_t  key,
	output logic      out_valid,
	output fcs_word_t out_word
);

	localparam logic [3:0] RIDX = 4'(ROUND_IDX % 16);
	localparam bit         LAST = (ROUND_IDX == ROUNDS - 1);

	logic [15:0][7:0] key_bytes;
	logic [3:0]       pos;
	logic [7:0]       mixed;
	logic [15:0]      doubled;
	logic [7:0]       f;
	fcs_word_t        next_word;
	logic             valid_s1;
	fcs_word_t        word_s1;

	assign key_bytes = {key.high, key.low};

	// key position is fixed by the round number and key length; decrypt walks it backward
	always_comb begin
		if (key.mode == KEY_LEN_16) begin
			pos = (in_word.opcode == OP_DECRYPT) ? ~RIDX : RIDX;
		end else begin
			pos = (in_word.opcode == OP_DECRYPT) ? {1'b0, ~RIDX[2:0]} : {1'b0, RIDX[2:0]};
		end
	end

	assign mixed   = fcs_sbox(in_word.right) ^ key_bytes[pos];
	assign doubled = {mixed, mixed};
	assign f       = doubled[15-ROTATE_BITS -: 8] ^ in_word.left;

	always_comb begin
		next_word.opcode = in_word.opcode;
		if (LAST) begin
			next_word.left  = f;
			next_word.right = in_word.right;
		end else begin
			next_word.left  = in_word.right;
			next_word.right = f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= next_word;
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule
